/* hw/rtl/pcrm_pkg.sv */
// ----------------------------------------------------------------------------
// PDCCH candidate RB mapper package
// Shared constants, register indexes, divider operation codes and the
// command and status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package pcrm_pkg;

  // Block limits.
  localparam int MAX_RB       = 320;
  localparam int REGS_PER_CCE = 6;
  localparam int NUM_LEVELS   = 5;
  localparam int MASK_WORDS   = (MAX_RB + 63) / 64;
  localparam int WIDX_W       = 3;

  // Width of the shared divider and of all REG arithmetic.
  localparam int DIV_W   = 12;
  localparam int DIV_CNT_W = 4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CORESET_RBS      = 3'd0;
  localparam logic [2:0] CFG_CORESET_SYMBOLS  = 3'd1;
  localparam logic [2:0] CFG_BUNDLE_SIZE      = 3'd2;
  localparam logic [2:0] CFG_INTERLEAVER_ROWS = 3'd3;
  localparam logic [2:0] CFG_BUNDLE_SHIFT     = 3'd4;
  localparam logic [2:0] CFG_INTERLEAVED_MODE = 3'd5;

  // Divider operations, in the order the controller issues them.
  localparam logic [2:0] DIV_OFF  = 3'd1;  // candidate offset
  localparam logic [2:0] DIV_BASE = 3'd2;  // offset modulo usable CCE groups
  localparam logic [2:0] DIV_NB   = 3'd3;  // bundle count
  localparam logic [2:0] DIV_COLS = 3'd4;  // interleaver columns
  localparam logic [2:0] DIV_J    = 3'd5;  // first bundle and REG within it
  localparam logic [2:0] DIV_JR   = 3'd6;  // interleaver row and column
  localparam logic [2:0] DIV_F    = 3'd7;  // interleaved bundle number

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic       div_capture;
    logic [2:0] div_sel;
    logic       reg_map;
    logic       reg_set;
    logic       advance;
    logic       out_next;
  } pcrm_cmd_t;

  typedef struct packed {
    logic div_done;
    logic div_busy;
    logic loop_done;
    logic map_ok;
    logic need_f;
    logic last_word;
  } pcrm_stat_t;

endpackage

/* hw/rtl/pcrm_in_if.sv */
// ----------------------------------------------------------------------------
// Candidate input channel
// Valid/ready channel that carries one PDCCH candidate description.
// ----------------------------------------------------------------------------
interface pcrm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] level_log;
  logic [2:0] candidate_index;
  logic [3:0] candidate_count;

  modport source(output valid, level_log, candidate_index, candidate_count, input ready);
  modport sink(input valid, level_log, candidate_index, candidate_count, output ready);
endinterface

/* hw/rtl/pcrm_out_if.sv */
// ----------------------------------------------------------------------------
// RB mask output channel
// Valid/ready channel that carries one 64-RB occupancy word.
// ----------------------------------------------------------------------------
interface pcrm_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] rb_mask_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source(output valid, rb_mask_word, word_index, last_word, input ready);
  modport sink(input valid, rb_mask_word, word_index, last_word, output ready);
endinterface

/* hw/rtl/pcrm_div.sv */
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned divider, one quotient bit per cycle, giving quotient
// and remainder with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module pcrm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pcrm_pkg::DIV_W-1:0] num,
  input  logic [pcrm_pkg::DIV_W-1:0] den,
  output logic [pcrm_pkg::DIV_W-1:0] quo,
  output logic [pcrm_pkg::DIV_W-1:0] rem,
  output logic                       busy,
  output logic                       done
);

  logic [pcrm_pkg::DIV_W-1:0]     dvs;
  logic [pcrm_pkg::DIV_CNT_W-1:0] cnt;
  logic [pcrm_pkg::DIV_W:0]       shifted;
  logic [pcrm_pkg::DIV_W:0]       diff;
  logic                           fits;

  // One trial subtraction per cycle.
  assign shifted = {rem, quo[pcrm_pkg::DIV_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == pcrm_pkg::DIV_CNT_W'(pcrm_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient and remainder shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      dvs <= den;
    end else if (busy) begin
      quo <= {quo[pcrm_pkg::DIV_W-2:0], fits};
      rem <= fits ? diff[pcrm_pkg::DIV_W-1:0] : shifted[pcrm_pkg::DIV_W-1:0];
    end
  end

endmodule

/* hw/rtl/pcrm_ctrl.sv */
// ----------------------------------------------------------------------------
// RB mapper controller
// State machine that sequences the setup divisions, walks the candidate's
// REG positions one at a time and then streams out the mask words.
// ----------------------------------------------------------------------------
module pcrm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  pcrm_pkg::pcrm_stat_t stat,
  output pcrm_pkg::pcrm_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LAUNCH = 3'd1;
  localparam logic [2:0] S_WAIT   = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_MAP    = 3'd4;
  localparam logic [2:0] S_SET    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] step;
  logic [2:0] step_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // Next state and datapath commands.
  always_comb begin
    state_next      = state;
    step_next       = step;
    cmd             = '0;
    cmd.div_sel     = step;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          step_next  = pcrm_pkg::DIV_OFF;
          state_next = S_LAUNCH;
        end
      end
      S_LAUNCH: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        if (stat.div_done) begin
          cmd.div_capture = 1'b1;
          if (step == pcrm_pkg::DIV_F) begin
            state_next = S_MAP;
          end else if (step == pcrm_pkg::DIV_JR) begin
            state_next = S_CHECK;
          end else begin
            step_next  = step + 1'b1;
            state_next = S_LAUNCH;
          end
        end
      end
      S_CHECK: begin
        if (stat.loop_done) begin
          state_next = S_OUT;
        end else if (!stat.map_ok) begin
          cmd.advance = 1'b1;
        end else if (stat.need_f) begin
          step_next  = pcrm_pkg::DIV_F;
          state_next = S_LAUNCH;
        end else begin
          state_next = S_MAP;
        end
      end
      S_MAP: begin
        cmd.reg_map = 1'b1;
        state_next  = S_SET;
      end
      S_SET: begin
        cmd.reg_set = 1'b1;
        cmd.advance = 1'b1;
        state_next  = S_CHECK;
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.out_next = 1'b1;
          if (stat.last_word) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= pcrm_pkg::DIV_OFF;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

/* hw/rtl/pcrm_dp.sv */
// ----------------------------------------------------------------------------
// RB mapper datapath
// Configuration registers, candidate geometry, the REG walk counters, the
// bundle map and the RB occupancy words, with the shared divider.
// ----------------------------------------------------------------------------
module pcrm_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [8:0]           cfg_data,
  input  logic [2:0]           level_log,
  input  logic [2:0]           candidate_index,
  input  logic [3:0]           candidate_count,
  input  pcrm_pkg::pcrm_cmd_t  cmd,
  output pcrm_pkg::pcrm_stat_t stat,
  output logic [63:0]          rb_mask_word,
  output logic [2:0]           word_index,
  output logic                 last_word
);

  localparam int W = pcrm_pkg::DIV_W;

  // Configuration registers.
  logic [8:0] coreset_rbs;
  logic [1:0] coreset_symbols;
  logic [2:0] bundle_size;
  logic [2:0] interleaver_rows;
  logic [8:0] bundle_shift;
  logic       interleaved_mode;

  // Per-candidate state.
  logic [2:0]   lvl;
  logic [2:0]   cand;
  logic [3:0]   cnt;
  logic [7:0]   ncce;
  logic [W-1:0] off;
  logic [W-1:0] pos;
  logic [W-1:0] pos_end;
  logic [W-1:0] nb;
  logic [W-1:0] cols;
  logic [W-1:0] j;
  logic [2:0]   pm;
  logic [W-1:0] jq;
  logic [2:0]   jr;
  logic [W-1:0] f;
  logic         f_valid;
  logic [W-1:0] reg_q;
  logic         reg_ok;
  logic [63:0]  occ [pcrm_pkg::MASK_WORDS];
  logic [pcrm_pkg::WIDX_W-1:0] widx;

  logic [10:0]  nreg;
  logic [22:0]  ncce_prod;
  logic [4:0]   al;
  logic [7:0]   nfloor_raw;
  logic [7:0]   nfloor;
  logic [W-1:0] div_num;
  logic [W-1:0] div_den;
  logic [W-1:0] div_quo;
  logic [W-1:0] div_rem;
  logic [W-1:0] base_cce;
  logic [W-1:0] base6;
  logic [W-1:0] f_sel;
  logic [W-1:0] reg_calc;
  logic [20:0]  third;
  logic [10:0]  rb;
  logic [8:0]   rbs_c;
  logic [9:0]   words_raw;
  logic [2:0]   words;
  logic [2:0]   pm_inc;
  logic [2:0]   jr_inc;

  assign nreg       = 11'(coreset_rbs) * 11'(coreset_symbols);
  // CCE count is nreg / 6 by reciprocal multiplication, exact below 8192.
  assign ncce_prod  = 23'(nreg) * 23'(2731);
  assign al         = 5'(1) << lvl;
  assign nfloor_raw = ncce >> lvl;
  assign nfloor     = (nfloor_raw == 8'd0) ? 8'd1 : nfloor_raw;

  // Divider operand selection.
  always_comb begin
    unique case (cmd.div_sel)
      pcrm_pkg::DIV_OFF: begin
        div_num = W'(cand) * W'(ncce);
        div_den = W'({4'd0, cnt} << lvl);
      end
      pcrm_pkg::DIV_BASE: begin
        div_num = off;
        div_den = W'(nfloor);
      end
      pcrm_pkg::DIV_NB: begin
        div_num = W'(nreg);
        div_den = W'(bundle_size);
      end
      pcrm_pkg::DIV_COLS: begin
        div_num = W'(nreg);
        div_den = W'(interleaver_rows) * W'(bundle_size);
      end
      pcrm_pkg::DIV_J: begin
        div_num = pos;
        div_den = W'(bundle_size);
      end
      pcrm_pkg::DIV_JR: begin
        div_num = j;
        div_den = W'(interleaver_rows);
      end
      pcrm_pkg::DIV_F: begin
        div_num = W'(jr * cols) + jq + W'(bundle_shift);
        div_den = nb;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  pcrm_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (div_num),
    .den  (div_den),
    .quo  (div_quo),
    .rem  (div_rem),
    .busy (stat.div_busy),
    .done (stat.div_done)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      coreset_rbs      <= 9'd48;
      coreset_symbols  <= 2'd1;
      bundle_size      <= 3'd6;
      interleaver_rows <= 3'd2;
      bundle_shift     <= 9'd0;
      interleaved_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcrm_pkg::CFG_CORESET_RBS:      coreset_rbs      <= cfg_data;
        pcrm_pkg::CFG_CORESET_SYMBOLS:  coreset_symbols  <= cfg_data[1:0];
        pcrm_pkg::CFG_BUNDLE_SIZE:      bundle_size      <= cfg_data[2:0];
        pcrm_pkg::CFG_INTERLEAVER_ROWS: interleaver_rows <= cfg_data[2:0];
        pcrm_pkg::CFG_BUNDLE_SHIFT:     bundle_shift     <= cfg_data;
        pcrm_pkg::CFG_INTERLEAVED_MODE: interleaved_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // First REG position: six times the first CCE, which is AL times the
  // offset modulo the usable CCE groups.
  assign base_cce = W'(div_rem[7:0]) << lvl;
  assign base6    = W'({base_cce, 2'b00}) + W'({base_cce, 1'b0});

  // REG number from bundle number, then RB from REG (time-first numbering).
  assign f_sel    = interleaved_mode ? f : j;
  assign reg_calc = W'(bundle_size * f_sel) + W'(pm);
  assign third    = 21'(reg_q[10:0]) * 21'(683);
  always_comb begin
    unique case (coreset_symbols)
      2'd2:    rb = reg_q[11:1];
      2'd3:    rb = third[20:10] >> 1;
      default: rb = reg_q[10:0];
    endcase
  end

  assign pm_inc = pm + 1'b1;
  assign jr_inc = jr + 1'b1;

  // Status toward the controller.
  assign stat.loop_done = (pos == pos_end) || (bundle_size == 3'd0) ||
                          (coreset_symbols == 2'd0);
  assign stat.map_ok    = (nb != '0) &&
                          (interleaved_mode ? ((interleaver_rows != 3'd0) && (jq < cols))
                                            : (j < nb));
  assign stat.need_f    = interleaved_mode && !f_valid;

  // Candidate geometry and the REG walk.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lvl     <= (level_log >= 3'(pcrm_pkg::NUM_LEVELS)) ?
                 3'(pcrm_pkg::NUM_LEVELS - 1) : level_log;
      cand    <= candidate_index;
      cnt     <= (candidate_count == 4'd0) ? 4'd1 : candidate_count;
      ncce    <= ncce_prod[21:14];
      f_valid <= 1'b0;
    end
    if (cmd.div_capture) begin
      unique case (cmd.div_sel)
        pcrm_pkg::DIV_OFF:  off  <= div_quo;
        pcrm_pkg::DIV_BASE: begin
          pos     <= base6;
          pos_end <= base6 + W'({al, 2'b00}) + W'({al, 1'b0});
        end
        pcrm_pkg::DIV_NB:   nb   <= div_quo;
        pcrm_pkg::DIV_COLS: cols <= div_quo;
        pcrm_pkg::DIV_J: begin
          j  <= div_quo;
          pm <= div_rem[2:0];
        end
        pcrm_pkg::DIV_JR: begin
          jq <= div_quo;
          jr <= div_rem[2:0];
        end
        pcrm_pkg::DIV_F: begin
          f       <= div_rem;
          f_valid <= 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (cmd.reg_map) begin
      reg_q  <= reg_calc;
      reg_ok <= (reg_calc < W'(nreg));
    end
    // Step to the next REG position; a new bundle needs a new map entry.
    if (cmd.advance) begin
      pos <= pos + 1'b1;
      if (pm_inc == bundle_size) begin
        pm      <= 3'd0;
        j       <= j + 1'b1;
        f_valid <= 1'b0;
        if (jr_inc == interleaver_rows) begin
          jr <= 3'd0;
          jq <= jq + 1'b1;
        end else begin
          jr <= jr_inc;
        end
      end else begin
        pm <= pm_inc;
      end
    end
  end

  // Occupancy words and the output word counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      widx <= '0;
    end else if (cmd.load) begin
      widx <= '0;
    end else if (cmd.out_next) begin
      widx <= widx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < pcrm_pkg::MASK_WORDS; i++) begin
        occ[i] <= '0;
      end
    end else if (cmd.reg_set && reg_ok && (rb < 11'(pcrm_pkg::MAX_RB))) begin
      occ[rb[8:6]][rb[5:0]] <= 1'b1;
    end
  end

  // Word count from the CORESET width, at least one word.
  assign rbs_c     = (coreset_rbs > 9'(pcrm_pkg::MAX_RB)) ? 9'(pcrm_pkg::MAX_RB) : coreset_rbs;
  assign words_raw = ({1'b0, rbs_c} + 10'd63) >> 6;
  assign words     = (words_raw == 10'd0) ? 3'd1 : words_raw[2:0];

  assign rb_mask_word   = occ[widx];
  assign word_index     = widx;
  assign last_word      = (widx == words - 1'b1);
  assign stat.last_word = last_word;

endmodule

/* hw/rtl/pdcch_candidate_rb_mapper.sv */
// ----------------------------------------------------------------------------
// PDCCH candidate RB mapper
// Maps a common-search-space PDCCH candidate to its CORESET resource blocks
// and reports them as 64-RB occupancy words.
// ----------------------------------------------------------------------------
// One candidate is processed at a time. After the input transfer, six
// setup divisions run on a shared 12-bit bit-serial divider, then each
// of the candidate's 6*AL REG positions passes through the check, map and
// set states, or only the check state when it lies outside the bundle map;
// in interleaved mode every new REG bundle inside the map adds one more
// division. The result is 1 to 5 mask words, one transfer per cycle while
// the receiver is ready. The user must write configuration only while the
// block is idle; the block itself does not enforce this.
module pdcch_candidate_rb_mapper (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [8:0]       cfg_data,
  pcrm_in_if.sink          in_ch,
  pcrm_out_if.source       out_ch
);

  pcrm_pkg::pcrm_cmd_t  cmd;
  pcrm_pkg::pcrm_stat_t stat;

  pcrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pcrm_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .level_log      (in_ch.level_log),
    .candidate_index(in_ch.candidate_index),
    .candidate_count(in_ch.candidate_count),
    .cmd            (cmd),
    .stat           (stat),
    .rb_mask_word   (out_ch.rb_mask_word),
    .word_index     (out_ch.word_index),
    .last_word      (out_ch.last_word)
  );

`ifndef SYNTHESIS
  // Input is never taken while results are being delivered.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid)) else $error("input ready during output");

  // A new candidate starts work at once.
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready) else $error("ready after input");

  // Words of one candidate follow without a gap until the last one.
  a_words_run: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && !out_ch.last_word) |=> out_ch.valid)
    else $error("output word run broken");

  // The divider is never restarted while it works.
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !stat.div_busy) else $error("divider restarted while busy");
`endif

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// PDCCH candidate RB mapper testbench
// Sends candidate descriptions to the mapper across a range of CORESET
// settings and checks every occupancy word against a local prediction.
// The stimulus runs under several idle and stall patterns and includes a
// long output stall.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 50;
  localparam int HOLD_CYCLES    = 600;

  typedef struct packed {
    logic [63:0] mask;
    logic [2:0]  idx;
    logic        last;
  } rb_word_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [8:0] cfg_data;

  pcrm_in_if  in_ch();
  pcrm_out_if out_ch();

  pdcch_candidate_rb_mapper dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Local copy of the configuration registers.
  int unsigned coreset_rbs, coreset_symbols, bundle_len, rows, shift, interleaved;

  rb_word_t    pending_words[$];
  int unsigned mismatches = 0;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_cycles = 0;
  int unsigned quiet_cycles = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bundle map lookup; returns 0 when the bundle lies outside the map.
  function automatic bit bundle_lookup(input int unsigned j, input int unsigned nreg,
                                       output int unsigned f);
    int unsigned nb, cols;
    f = 0;
    if (bundle_len == 0) return 0;
    nb = nreg / bundle_len;
    if (nb == 0) return 0;
    if (interleaved != 0) begin
      if (rows == 0) return 0;
      cols = nreg / (rows * bundle_len);
      if (j >= cols * rows) return 0;
      f = ((j % rows) * cols + j / rows + shift) % nb;
    end else begin
      if (j >= nb) return 0;
      f = j;
    end
    return 1;
  endfunction

  // Work out the occupancy words of one candidate and queue them.
  task automatic predict_rb_words(input int unsigned lvl, input int unsigned cand,
                                  input int unsigned cnt);
    logic [63:0] occ [pcrm_pkg::MASK_WORDS];
    int unsigned al, nreg, ncce, nfloor, off, base, pos, f, regn, rb, rbs, words;
    rb_word_t    w;
    for (int i = 0; i < pcrm_pkg::MASK_WORDS; i++) occ[i] = '0;
    if (lvl >= pcrm_pkg::NUM_LEVELS) lvl = pcrm_pkg::NUM_LEVELS - 1;
    if (cnt == 0) cnt = 1;
    al = 1 << lvl;
    nreg = coreset_rbs * coreset_symbols;
    ncce = nreg / pcrm_pkg::REGS_PER_CCE;
    nfloor = ncce / al;
    if (nfloor < 1) nfloor = 1;
    off = (cand * ncce) / (al * cnt);
    base = al * (off % nfloor);
    if (bundle_len != 0 && coreset_symbols != 0) begin
      for (int unsigned k = 0; k < al; k++) begin
        for (int unsigned r = 0; r < pcrm_pkg::REGS_PER_CCE; r++) begin
          pos = (base + k) * pcrm_pkg::REGS_PER_CCE + r;
          if (!bundle_lookup(pos / bundle_len, nreg, f)) continue;
          regn = bundle_len * f + pos % bundle_len;
          if (regn >= nreg) continue;
          rb = regn / coreset_symbols;
          if (rb >= pcrm_pkg::MAX_RB) continue;
          occ[rb >> 6][rb & 63] = 1'b1;
        end
      end
    end
    rbs = (coreset_rbs < pcrm_pkg::MAX_RB) ? coreset_rbs : pcrm_pkg::MAX_RB;
    words = (rbs + 63) / 64;
    if (words < 1) words = 1;
    if (words > pcrm_pkg::MASK_WORDS) words = pcrm_pkg::MASK_WORDS;
    for (int unsigned i = 0; i < words; i++) begin
      w.mask = occ[i];
      w.idx  = i[2:0];
      w.last = (i + 1 == words);
      pending_words = {pending_words, w};
    end
  endtask

  // Output side: random stalls, long holds, result checks and the watchdog.
  always @(posedge clk) begin
    rb_word_t exp_w;
    if (out_ch.valid && out_ch.ready) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: mask=%h idx=%0d last=%0b",
                   out_ch.rb_mask_word, out_ch.word_index, out_ch.last_word);
      end else begin
        exp_w = pending_words.pop_front();
        if (out_ch.rb_mask_word !== exp_w.mask || out_ch.word_index !== exp_w.idx ||
            out_ch.last_word !== exp_w.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"word mismatch: expected mask=%h idx=%0d last=%0b, ",
                      "got mask=%h idx=%0d last=%0b"},
                     exp_w.mask, exp_w.idx, exp_w.last,
                     out_ch.rb_mask_word, out_ch.word_index, out_ch.last_word);
        end
      end
    end
    // A requested hold keeps the receiver off for a counted stretch.
    if (hold_cycles != 0) begin
      hold_cycles  <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_requests != holds_served) begin
      hold_cycles  <= HOLD_CYCLES;
      holds_served <= hold_requests;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
    if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (!rst) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // Write one configuration register.
  task automatic write_reg(input logic [2:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[8:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Program a complete CORESET setting; the block must be idle.
  task automatic apply_setting(input int unsigned rbs, input int unsigned sym,
                               input int unsigned l, input int unsigned r,
                               input int unsigned sh, input int unsigned mode);
    coreset_rbs = rbs; coreset_symbols = sym; bundle_len = l;
    rows = r; shift = sh; interleaved = mode;
    write_reg(pcrm_pkg::CFG_CORESET_RBS, rbs);
    write_reg(pcrm_pkg::CFG_CORESET_SYMBOLS, sym);
    write_reg(pcrm_pkg::CFG_BUNDLE_SIZE, l);
    write_reg(pcrm_pkg::CFG_INTERLEAVER_ROWS, r);
    write_reg(pcrm_pkg::CFG_BUNDLE_SHIFT, sh);
    write_reg(pcrm_pkg::CFG_INTERLEAVED_MODE, mode);
  endtask

  // Random setting; most CORESETs are narrow to keep items short.
  task automatic apply_random_setting();
    int unsigned rbs;
    rbs = ($urandom_range(0, 3) == 0) ? 6 * $urandom_range(1, 45)
                                      : 6 * $urandom_range(1, 12);
    apply_setting(rbs, $urandom_range(1, 3), $urandom_range(2, 6), $urandom_range(2, 6),
                  $urandom_range(0, 274), $urandom_range(0, 1));
  endtask

  // Offer one candidate; valid stays high afterwards unless a gap follows.
  task automatic send_candidate(input int unsigned lvl, input int unsigned cand,
                                input int unsigned cnt);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.level_log       <= lvl[2:0];
    in_ch.candidate_index <= cand[2:0];
    in_ch.candidate_count <= cnt[3:0];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_rb_words(lvl, cand, cnt);
  endtask

  // Stop offering and wait until every queued word has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_candidate();
    send_candidate($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 15));
  endtask

  // Directed: reset setting, extreme widths, every level and count corner.
  task automatic test_directed();
    src_idle_pct = 0; snk_stall_pct = 0;
    send_candidate(0, 0, 1);
    send_candidate(3, 1, 2);
    drain();
    apply_setting(6, 1, 2, 2, 0, 0);
    send_candidate(0, 0, 1);
    send_candidate(4, 7, 8);
    send_candidate(7, 7, 0);
    drain();
    apply_setting(270, 3, 6, 6, 274, 1);
    for (int unsigned l = 0; l < 8; l++) send_candidate(l, l, 15 - 2 * l);
    drain();
    apply_setting(270, 3, 3, 2, 0, 0);
    send_candidate(4, 0, 1);
    send_candidate(2, 7, 8);
    send_candidate(5, 3, 0);
    drain();
    apply_setting(264, 2, 2, 3, 137, 1);
    send_candidate(0, 7, 1);
    send_candidate(1, 5, 4);
    send_candidate(4, 1, 2);
    drain();
  endtask

  // Random candidates under one idle pattern with a few setting changes.
  task automatic test_random_phase(input int unsigned src_pct, input int unsigned snk_pct,
                                   input int unsigned n);
    src_idle_pct = src_pct; snk_stall_pct = snk_pct;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 12 == 0) begin
        drain();
        apply_random_setting();
      end
      send_random_candidate();
    end
    drain();
  endtask

  // Long output stall while candidates keep arriving.
  task automatic test_backpressure();
    src_idle_pct = 0; snk_stall_pct = 0;
    apply_setting(270, 1, 6, 2, 5, 0);
    hold_requests++;
    for (int unsigned i = 0; i < 8; i++) send_random_candidate();
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we <= 1'b0; cfg_index <= '0; cfg_data <= '0;
    in_ch.valid <= 1'b0; in_ch.level_log <= '0;
    in_ch.candidate_index <= '0; in_ch.candidate_count <= '0;
    src_idle_pct = 0; snk_stall_pct = 0;
    coreset_rbs = 48; coreset_symbols = 1; bundle_len = 6;
    rows = 2; shift = 0; interleaved = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_phase(0, 0, 30);
    test_random_phase(76, 0, 30);
    test_random_phase(0, 76, 30);
    test_random_phase(11, 11, 30);
    test_backpressure();
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
